// ===== rtl/mcbd_pkg.sv =====
// Shared types, codes and constant tables of the memory card block device.
// No dependencies.
package mcbd_pkg;

  localparam int unsigned MaxBlockW = 8;
  localparam logic [31:0] CardFn = 32'h0200_0000;
  localparam logic [7:0]  FuncInfo    = 8'd1;
  localparam logic [7:0]  FuncMedia   = 8'd10;
  localparam logic [7:0]  FuncRead    = 8'd11;
  localparam logic [7:0]  FuncWrite   = 8'd12;
  localparam logic [7:0]  FuncLastErr = 8'd13;
  localparam logic [7:0]  InfoWords   = 8'd28;
  localparam logic [7:0]  MediaWords  = 8'd7;
  localparam logic [7:0]  ReadWords   = 8'd130;

  typedef enum logic [2:0] {
    RSP_STATUS  = 3'd0,
    RSP_DATA    = 3'd1,
    RSP_OK      = 3'd2,
    RSP_BADFN   = 3'd3,
    RSP_UNKNOWN = 3'd4
  } resp_code_e;

  typedef enum logic [2:0] {
    K_INFO    = 3'd0,
    K_MEDIA   = 3'd1,
    K_READ    = 3'd2,
    K_WRITE   = 3'd3,
    K_LASTERR = 3'd4,
    K_UNKNOWN = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0]  func;
    logic [31:0] function_word;
    logic [31:0] location_word;
    logic [31:0] data_word;
    logic        last_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  response;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
    logic [2:0]  words_valid;
    logic        reply_last;
  } rsp_t;

  // classified command between front and back
  typedef struct packed {
    kind_e                 kind;
    logic                  fn_ok;
    logic [31:0]           loc;
    logic [31:0]           data;
    logic                  last;
    logic [MaxBlockW-1:0]  block;
    logic [1:0]            phase;
  } cmd_t;

  function automatic logic [31:0] info_word(input logic [4:0] idx);
    logic [31:0] w;
    unique case (idx)
      5'd0:  w = CardFn;
      5'd1:  w = 32'h0041_0F00;
      5'd4:  w = 32'h6D45_00FF;
      5'd5:  w = 32'h7461_6C75;
      5'd6:  w = 32'h5620_6465;
      5'd7:  w = 32'h0000_554D;
      5'd12: w = 32'h656B_6146;
      5'd13: w = 32'h7962_2064;
      5'd14: w = 32'h6B72_6420;
      5'd15: w = 32'h6152_4949;
      5'd16: w = 32'h6C65_697A;
      5'd17: w = 32'h2026_2620;
      5'd18: w = 32'h755A_655A;
      5'd19: w = 32'h6D20_2C20;
      5'd20: w = 32'h2065_6461;
      5'd21: w = 32'h2072_6F66;
      5'd22: w = 32'h6C6C_756E;
      5'd23: w = 32'h0000_4344;
      5'd27: w = 32'h8200_7C00;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] media_word(input logic [2:0] idx);
    logic [31:0] w;
    unique case (idx)
      3'd0: w = CardFn;
      3'd1: w = 32'h0000_00FF;
      3'd2: w = 32'h00FE_00FF;
      3'd3: w = 32'h00FD_0001;
      3'd4: w = 32'h0000_000D;
      3'd5: w = 32'h001F_00C8;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mcbd_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module mcbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/mcbd_fifo.sv =====
// Short command queue between front and back.
// Depends on mcbd_pkg.
module mcbd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcbd_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mcbd_pkg::cmd_t rdata_o
);
  mcbd_pkg::cmd_t ent_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign rdata_o = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end
endmodule

// ===== rtl/mcbd_front.sv =====
// Front end: takes request beats, reduces the block number and classifies.
// Depends on mcbd_pkg.
module mcbd_front #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mcbd_pkg::req_t  req_i,
  input  logic            hold_i,
  output logic            full_o,
  output logic            q_push_o,
  output mcbd_pkg::cmd_t  q_data_o,
  input  logic            q_full_i
);
  localparam int unsigned BlockW = $clog2(NUM_BLOCKS);
  // ceil(2^32 / NUM_BLOCKS): exact quotient for 16-bit block numbers
  localparam logic [32:0] RecipM = 33'(((64'd1 << 32) + 64'(NUM_BLOCKS) - 64'd1)
                                       / 64'(NUM_BLOCKS));

  logic            fv_q;
  mcbd_pkg::req_t  req_q;
  logic [15:0]     quo_q, quo_d;
  logic [15:0]     blk_in, blk_q;
  logic [48:0]     prod;
  logic [24:0]     qn;
  logic [15:0]     rem;
  logic            accept, move;

  assign blk_in = {req_i.location_word[23:16], req_i.location_word[31:24]};
  assign prod   = 49'(blk_in) * 49'(RecipM);
  assign quo_d  = prod[47:32];

  assign move     = fv_q && !q_full_i;
  assign full_o   = hold_i || (fv_q && q_full_i);
  assign accept   = push_i && !full_o;
  assign q_push_o = move;

  assign blk_q = {req_q.location_word[23:16], req_q.location_word[31:24]};
  assign qn    = 25'(quo_q) * 25'(NUM_BLOCKS);
  assign rem   = blk_q - qn[15:0];

  always_comb begin
    q_data_o       = '0;
    q_data_o.fn_ok = req_q.function_word[25];
    q_data_o.loc   = req_q.location_word;
    q_data_o.data  = req_q.data_word;
    q_data_o.last  = req_q.last_word;
    q_data_o.phase = req_q.location_word[9:8];
    q_data_o.block[BlockW-1:0] = rem[BlockW-1:0];
    unique case (req_q.func)
      mcbd_pkg::FuncInfo:    q_data_o.kind = mcbd_pkg::K_INFO;
      mcbd_pkg::FuncMedia:   q_data_o.kind = mcbd_pkg::K_MEDIA;
      mcbd_pkg::FuncRead:    q_data_o.kind = mcbd_pkg::K_READ;
      mcbd_pkg::FuncWrite:   q_data_o.kind = mcbd_pkg::K_WRITE;
      mcbd_pkg::FuncLastErr: q_data_o.kind = mcbd_pkg::K_LASTERR;
      default:               q_data_o.kind = mcbd_pkg::K_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (move) begin
      fv_q <= 1'b0;
    end
  end
endmodule

// ===== rtl/mcbd_back.sv =====
// Back end: clears and owns the card store, runs commands, builds result beats.
// Depends on mcbd_pkg and mcbd_ram.
module mcbd_back #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  mcbd_pkg::cmd_t  q_data_i,
  output logic            q_pop_o,
  output logic            clearing_o,
  output logic            empty_o,
  input  logic            pop_i,
  output mcbd_pkg::rsp_t  rsp_o
);
  localparam int unsigned BlockW = $clog2(NUM_BLOCKS);
  localparam int unsigned StoreWords = NUM_BLOCKS * 128;
  localparam int unsigned AddrW = $clog2(StoreWords);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_CAP   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [AddrW-1:0]     clr_q, clr_d;
  mcbd_pkg::cmd_t       cmd_q, cmd_d;
  logic [7:0]           n_q, n_d, widx_q, widx_d;
  logic [2:0]           slot_q, slot_d;
  logic [31:0]          wbuf_q [4];
  logic [31:0]          wbuf_d [4];
  mcbd_pkg::resp_code_e code_q, code_d;
  logic [4:0]           wcnt_q, wcnt_d;
  logic                 ov_q, ov_d;
  mcbd_pkg::rsp_t       out_q, out_d;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_addr;
  logic [31:0]          ram_wdata, ram_rdata;
  logic [31:0]          cword, new_word;
  logic                 put;
  logic [6:0]           ridx;

  mcbd_ram #(.Width(32), .Depth(StoreWords)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = (state_q == ST_CLEAR);
  assign empty_o    = !ov_q;
  assign rsp_o      = out_q;
  assign ridx       = 7'(widx_q - 8'd2);

  // constant reply words
  always_comb begin
    unique case (cmd_q.kind)
      mcbd_pkg::K_INFO:  cword = mcbd_pkg::info_word(widx_q[4:0]);
      mcbd_pkg::K_MEDIA: cword = mcbd_pkg::media_word(widx_q[2:0]);
      default:           cword = (widx_q == 8'd0) ? mcbd_pkg::CardFn : cmd_q.loc;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    n_d       = n_q;
    widx_d    = widx_q;
    slot_d    = slot_q;
    wbuf_d    = wbuf_q;
    code_d    = code_q;
    wcnt_d    = wcnt_q;
    ov_d      = ov_q && !pop_i;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = q_data_i.data;
    q_pop_o   = 1'b0;
    put       = 1'b0;
    new_word  = cword;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(StoreWords - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          widx_d  = '0;
          slot_d  = '0;
          for (int i = 0; i < 4; i++) wbuf_d[i] = '0;
          if (q_data_i.kind == mcbd_pkg::K_WRITE) begin
            if (q_data_i.fn_ok) begin
              ram_we   = 1'b1;
              ram_addr = {q_data_i.block[BlockW-1:0], q_data_i.phase, wcnt_q};
              wcnt_d   = wcnt_q + 5'd1;
            end
            if (q_data_i.last) begin
              wcnt_d  = '0;
              n_d     = '0;
              code_d  = q_data_i.fn_ok ? mcbd_pkg::RSP_OK : mcbd_pkg::RSP_BADFN;
              state_d = ST_EMIT;
            end
          end else begin
            wcnt_d = '0;
            unique case (q_data_i.kind)
              mcbd_pkg::K_INFO: begin
                n_d = mcbd_pkg::InfoWords; code_d = mcbd_pkg::RSP_STATUS;
              end
              mcbd_pkg::K_MEDIA: begin
                n_d    = q_data_i.fn_ok ? mcbd_pkg::MediaWords : 8'd0;
                code_d = q_data_i.fn_ok ? mcbd_pkg::RSP_DATA : mcbd_pkg::RSP_BADFN;
              end
              mcbd_pkg::K_READ: begin
                n_d    = q_data_i.fn_ok ? mcbd_pkg::ReadWords : 8'd0;
                code_d = q_data_i.fn_ok ? mcbd_pkg::RSP_DATA : mcbd_pkg::RSP_BADFN;
              end
              mcbd_pkg::K_LASTERR: begin
                n_d = '0; code_d = mcbd_pkg::RSP_OK;
              end
              default: begin
                n_d = '0; code_d = mcbd_pkg::RSP_UNKNOWN;
              end
            endcase
            state_d = (n_d == 8'd0) ? ST_EMIT : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (cmd_q.kind == mcbd_pkg::K_READ && widx_q >= 8'd2) begin
          ram_addr = {cmd_q.block[BlockW-1:0], ridx};
          state_d  = ST_CAP;
        end else begin
          put = 1'b1;
        end
      end
      ST_CAP: begin
        new_word = ram_rdata;
        put      = 1'b1;
      end
      ST_EMIT: begin
        if (!ov_q || pop_i) begin
          ov_d              = 1'b1;
          out_d.response    = code_q;
          out_d.word_a      = wbuf_q[0];
          out_d.word_b      = wbuf_q[1];
          out_d.word_c      = wbuf_q[2];
          out_d.word_d      = wbuf_q[3];
          out_d.words_valid = slot_q;
          out_d.reply_last  = (widx_q == n_q);
          slot_d            = '0;
          for (int i = 0; i < 4; i++) wbuf_d[i] = '0;
          state_d = (widx_q == n_q) ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (put) begin
      wbuf_d[slot_q[1:0]] = new_word;
      slot_d  = slot_q + 3'd1;
      widx_d  = widx_q + 8'd1;
      state_d = (slot_q == 3'd3 || widx_d == n_q) ? ST_EMIT : ST_FETCH;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    n_q    <= n_d;
    widx_q <= widx_d;
    slot_q <= slot_d;
    wbuf_q <= wbuf_d;
    code_q <= code_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      wcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wcnt_q  <= wcnt_d;
      ov_q    <= ov_d;
    end
  end
endmodule

// ===== rtl/memory_card_block_device_top.sv =====
// Top level of the memory card block device command handler.
// Depends on mcbd_pkg, mcbd_front, mcbd_fifo, mcbd_back.
//
// Usage:
//  - Request side is a queue: a request beat (req_i) is taken when push_i is
//    high and full_o is low.
//  - Result side is a queue: the oldest result beat sits on rsp_o while
//    empty_o is low and is taken when pop_i is high.
//  - Each result beat carries up to four reply words; reply_last marks the
//    final beat of a reply. Write beats not marked last give no result.
//  - After reset the card store is swept to zero, one word per cycle:
//    NUM_BLOCKS*128 words (32768 at the default size). full_o stays high
//    during the sweep.
//  - A request passes a one-register front (block reduction by reciprocal
//    multiply) into a four-entry command queue, so requests keep flowing
//    while the back end is busy.
//  - Back end: a write beat with the function bit set is stored when it is popped.
//    Constant words are put in the fetch state, card words in a fetch and a
//    capture state (single RAM port, registered read), and each result beat
//    leaves through the emit state. A block read has 33 beats; the back end handles one command at a time.
//  - When the receiver stalls, the result register holds, the back end waits,
//    then the queue fills and full_o rises.
module memory_card_block_device_top #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  mcbd_pkg::req_t  req_i,
  output logic            empty_o,
  input  logic            pop_i,
  output mcbd_pkg::rsp_t  rsp_o
);
  logic           q_push, q_full, q_pop, q_empty, clearing;
  mcbd_pkg::cmd_t q_wdata, q_rdata;

  mcbd_front #(.NUM_BLOCKS(NUM_BLOCKS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .req_i    (req_i),
    .hold_i   (clearing),
    .full_o   (full_o),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  mcbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  mcbd_back #(.NUM_BLOCKS(NUM_BLOCKS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .rsp_o      (rsp_o)
  );
endmodule

// ===== verif/tb_memory_card_block_device_top.sv =====
// Self-checking testbench of memory_card_block_device_top: directed and random request
// beats, predicted reply beats compared in order. Depends on mcbd_pkg and the RTL top.
module tb_memory_card_block_device_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBlocks  = 256;
  localparam int unsigned BlockWords = 128;
  localparam int unsigned PhaseWords = 32;
  localparam int unsigned StoreWords = NumBlocks * BlockWords;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainWait  = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  logic full_o, empty_o;
  mcbd_pkg::req_t req_i = '0;
  mcbd_pkg::rsp_t rsp_o;

  always #4 clk_i = ~clk_i;

  memory_card_block_device_top #(.NUM_BLOCKS(NumBlocks)) i_dut (
    .clk_i, .rst_ni, .push_i, .full_o, .req_i, .empty_o, .pop_i, .rsp_o
  );

  // Shadow state of the card.
  logic [31:0] card_mirror [StoreWords];
  logic [4:0]  wr_word_cnt;

  mcbd_pkg::req_t pending_reqs [$];
  mcbd_pkg::rsp_t expected_rsps [$];
  int unsigned mismatches;
  int unsigned cycle_cnt;
  bit mid_drained;
  bit hold_sender;

  function automatic logic [31:0] fixed_info(int unsigned i);
    logic [31:0] w;
    case (i)
      0: w = mcbd_pkg::CardFn;
      1: w = 32'h0041_0F00;
      4: w = 32'h6D45_00FF;
      5: w = 32'h7461_6C75;
      6: w = 32'h5620_6465;
      7: w = 32'h0000_554D;
      12: w = 32'h656B_6146;
      13: w = 32'h7962_2064;
      14: w = 32'h6B72_6420;
      15: w = 32'h6152_4949;
      16: w = 32'h6C65_697A;
      17: w = 32'h2026_2620;
      18: w = 32'h755A_655A;
      19: w = 32'h6D20_2C20;
      20: w = 32'h2065_6461;
      21: w = 32'h2072_6F66;
      22: w = 32'h6C6C_756E;
      23: w = 32'h0000_4344;
      27: w = 32'h8200_7C00;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] fixed_media(int unsigned i);
    logic [31:0] w;
    case (i)
      0: w = mcbd_pkg::CardFn;
      1: w = 32'h0000_00FF;
      2: w = 32'h00FE_00FF;
      3: w = 32'h00FD_0001;
      4: w = 32'h0000_000D;
      5: w = 32'h001F_00C8;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  // Split a reply word list into four-word beats.
  task automatic queue_reply(input logic [31:0] words [$],
                             input mcbd_pkg::resp_code_e code);
    int unsigned n, nbeats, base, valid;
    mcbd_pkg::rsp_t r;
    n = words.size();
    nbeats = (n == 0) ? 1 : (n + 3) / 4;
    for (int unsigned b = 0; b < nbeats; b++) begin
      base = b * 4;
      valid = (n > base) ? n - base : 0;
      if (valid > 4) valid = 4;
      r = '0;
      r.response = code;
      if (valid > 0) r.word_a = words[base];
      if (valid > 1) r.word_b = words[base + 1];
      if (valid > 2) r.word_c = words[base + 2];
      if (valid > 3) r.word_d = words[base + 3];
      r.words_valid = valid[2:0];
      r.reply_last = (b + 1 == nbeats);
      expected_rsps.push_back(r);
    end
  endtask

  function automatic int unsigned card_block(logic [31:0] loc);
    return {loc[23:16], loc[31:24]} % NumBlocks;
  endfunction

  task automatic predict_reply(input mcbd_pkg::req_t q);
    logic [31:0] words [$];
    bit fn_ok;
    int unsigned idx;
    fn_ok = (q.function_word & mcbd_pkg::CardFn) != 0;
    words = {};
    if (q.func == mcbd_pkg::FuncWrite) begin
      if (fn_ok) begin
        idx = card_block(q.location_word) * BlockWords
            + (q.location_word[15:8] % 4) * PhaseWords + wr_word_cnt;
        card_mirror[idx] = q.data_word;
        wr_word_cnt++;
      end
      if (q.last_word) begin
        wr_word_cnt = '0;
        if (fn_ok) queue_reply(words, mcbd_pkg::RSP_OK);
        else queue_reply(words, mcbd_pkg::RSP_BADFN);
      end
      return;
    end
    wr_word_cnt = '0;
    case (q.func)
      mcbd_pkg::FuncInfo: begin
        for (int unsigned i = 0; i < 28; i++) words.push_back(fixed_info(i));
        queue_reply(words, mcbd_pkg::RSP_STATUS);
      end
      mcbd_pkg::FuncMedia:
        if (!fn_ok) queue_reply(words, mcbd_pkg::RSP_BADFN);
        else begin
          for (int unsigned i = 0; i < 7; i++) words.push_back(fixed_media(i));
          queue_reply(words, mcbd_pkg::RSP_DATA);
        end
      mcbd_pkg::FuncRead:
        if (!fn_ok) queue_reply(words, mcbd_pkg::RSP_BADFN);
        else begin
          words.push_back(mcbd_pkg::CardFn);
          words.push_back(q.location_word);
          for (int unsigned i = 0; i < BlockWords; i++)
            words.push_back(card_mirror[card_block(q.location_word) * BlockWords + i]);
          queue_reply(words, mcbd_pkg::RSP_DATA);
        end
      mcbd_pkg::FuncLastErr: queue_reply(words, mcbd_pkg::RSP_OK);
      default: queue_reply(words, mcbd_pkg::RSP_UNKNOWN);
    endcase
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Location word for block and phase, byte-swapped as on the bus.
  function automatic logic [31:0] make_loc(logic [15:0] blk, logic [7:0] ph,
                                            logic [7:0] junk);
    return {blk[7:0], blk[15:8], ph, junk};
  endfunction

  function automatic mcbd_pkg::req_t make_req(logic [7:0] f, logic [31:0] fw,
                                              logic [31:0] loc, logic [31:0] d, logic l);
    mcbd_pkg::req_t q;
    q.func = f; q.function_word = fw; q.location_word = loc;
    q.data_word = d; q.last_word = l;
    return q;
  endfunction

  // A whole write phase: n data beats, the last one marked.
  task automatic add_write_phase(logic [31:0] fw, logic [31:0] loc, int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      pending_reqs.push_back(make_req(mcbd_pkg::FuncWrite, fw, loc, $urandom(), i == n - 1));
  endtask

  // Driver: takes the next beat from the pending queue, with random gaps.
  int unsigned send_gap;
  always @(posedge clk_i) begin
    if (push_i && !full_o) begin
      predict_reply(req_i);
      void'(pending_reqs.pop_front());
    end
    if (push_i && full_o) begin
      // hold the current beat
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      push_i <= 1'b0;
    end else if (pending_reqs.size() > 0 && !hold_sender && rst_ni) begin
      req_i <= pending_reqs[0];
      push_i <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      push_i <= 1'b0;
    end
  end

  // Monitor: pops result beats with random stalls and checks them in order.
  int unsigned pop_gap;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (pop_i && !empty_o) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", rsp_o);
      end else begin
        if (rsp_o !== expected_rsps[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", expected_rsps[0], rsp_o);
        end
        void'(expected_rsps.pop_front());
      end
    end
    if (pop_gap != 0) begin
      pop_gap <= pop_gap - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
      pop_gap <= pick_gap();
    end
  end

  initial begin
    logic [31:0] fw_on, fw_off;
    int unsigned kind;
    fw_on = mcbd_pkg::CardFn;
    fw_off = ~mcbd_pkg::CardFn;
    send_gap = 0; pop_gap = 0; mismatches = 0; cycle_cnt = 0;
    mid_drained = 0; hold_sender = 0;
    wr_word_cnt = '0;
    foreach (card_mirror[i]) card_mirror[i] = '0;

    // Directed: every command, function bit on and off, extreme fields.
    pending_reqs.push_back(make_req(mcbd_pkg::FuncInfo, 32'h0, 32'h0, 32'h0, 1'b0));
    pending_reqs.push_back(make_req(mcbd_pkg::FuncMedia, fw_on, 32'h0, 32'h0, 1'b1));
    pending_reqs.push_back(make_req(mcbd_pkg::FuncMedia, fw_off, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(make_req(mcbd_pkg::FuncRead, fw_on,
                                    make_loc(16'h0, 8'h0, 8'h0), 32'h0, 1'b1));
    pending_reqs.push_back(make_req(mcbd_pkg::FuncRead, fw_off,
                                    make_loc(16'h5, 8'h0, 8'h0), 32'h0, 1'b1));
    add_write_phase(fw_on, make_loc(16'hFFFF, 8'hFF, 8'hFF), 3);   // block, phase wrap
    add_write_phase(fw_off, make_loc(16'h0001, 8'h0, 8'h0), 2);    // bad function
    add_write_phase(32'hFFFF_FFFF, make_loc(16'h0100, 8'h2, 8'h0), 1);
    pending_reqs.push_back(make_req(mcbd_pkg::FuncRead, 32'hFFFF_FFFF,
                                    make_loc(16'hFFFF, 8'h0, 8'h0), 32'h0, 1'b0));
    pending_reqs.push_back(make_req(mcbd_pkg::FuncLastErr, 32'h0, 32'h0, 32'h0, 1'b0));
    pending_reqs.push_back(make_req(8'hFF, fw_on, 32'h0, 32'h0, 1'b1));
    pending_reqs.push_back(make_req(8'h00, fw_on, 32'h0, 32'h0, 1'b0));
    pending_reqs.push_back(make_req(mcbd_pkg::FuncRead, fw_on,
                                    make_loc(16'h0000, 8'h0, 8'h0), 32'h0, 1'b1));

    // Reset, then release it; the driver holds its beat while full stays high during the post-reset sweep.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random part: mostly coherent write phases and reads, some noise.
    for (int unsigned n = 0; n < 165; ) begin
      kind = $urandom_range(0, 19);
      if (kind < 7) begin
        // overlong phase now and then
        int unsigned len;
        logic [31:0] fw;
        logic [15:0] blk;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 32);
        fw = ($urandom_range(0, 5) == 0) ? ($urandom() & fw_off) : ($urandom() | fw_on);
        blk = 16'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) blk = blk | 16'($urandom() & 32'hFF00);
        add_write_phase(fw, make_loc(blk, 8'($urandom()), 8'($urandom())), len);
        n += len;
      end else if (kind < 11) begin
        logic [31:0] fw;
        logic [15:0] blk;
        fw = ($urandom_range(0, 4) == 0) ? $urandom() : ($urandom() | fw_on);
        blk = 16'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) blk = blk | 16'($urandom() & 32'hFF00);
        pending_reqs.push_back(make_req(mcbd_pkg::FuncRead, fw,
          make_loc(blk, 8'($urandom()), 8'($urandom())), $urandom(), 1'($urandom())));
        n++;
      end else begin
        logic [7:0] f;
        case ($urandom_range(0, 4))
          0: f = mcbd_pkg::FuncInfo;
          1: f = mcbd_pkg::FuncMedia;
          2: f = mcbd_pkg::FuncLastErr;
          3: f = mcbd_pkg::FuncWrite;
          default: f = 8'($urandom());
        endcase
        pending_reqs.push_back(make_req(f, $urandom(), $urandom(), $urandom(),
                                        1'($urandom())));
        n++;
      end
      // Midway, let the reply side drain completely before sending on.
      if (n >= 90 && !mid_drained) begin
        wait (pending_reqs.size() == 0);
        hold_sender = 1;
        wait (expected_rsps.size() == 0);
        hold_sender = 0;
        mid_drained = 1;
      end
    end
    wait (pending_reqs.size() == 0 && !push_i);
    wait (expected_rsps.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== memory_card_block_device_top.f =====
rtl/mcbd_pkg.sv
rtl/mcbd_ram.sv
rtl/mcbd_fifo.sv
rtl/mcbd_front.sv
rtl/mcbd_back.sv
rtl/memory_card_block_device_top.sv
verif/tb_memory_card_block_device_top.sv
